[src/saw_oscillator_fm_release_macros.svh]
// Assertion helpers used by the checker.
`ifndef SAW_OSCILLATOR_FM_RELEASE_MACROS_SVH
`define SAW_OSCILLATOR_FM_RELEASE_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high
`define SOFR_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high
`define SOFR_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/sofr_pkg.sv]
`default_nettype none

package sofr_pkg;

   // default widths of the accumulators
   localparam int PHASE_BITS_DEF = 32;
   localparam int TAIL_BITS_DEF  = 16;

   // stream and register port widths
   localparam int REQ_DATA_W = 64;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 40;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   // request kinds carried on req_tuser
   typedef enum logic [REQ_USER_W-1:0] {
      CMD_TICK    = 2'd0,
      CMD_START   = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_STOP    = 2'd3
   } command_type;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_VOLUME   = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_FM_DEPTH = 1'b1;

   localparam logic [6:0] VOLUME_RESET = 7'd127;

   // bit-serial divide by the full-scale volume
   localparam int         DIV_W       = 25;
   localparam int         DIV_CNT_W   = $clog2(DIV_W);
   localparam logic [7:0] VOL_DIVISOR = 8'd127;

   localparam logic [16:0] SAMPLE_MAX = 17'h1FFFF;

   // serial multiplier operand width (widest multiplier operand is the FM factor)
   localparam int MPLIER_W = 32;

   // unity FM factor, Q1.31
   localparam logic [33:0] FM_UNITY = 34'h0_8000_0000;

endpackage

`default_nettype wire

[src/saw_oscillator_fm_release.sv]
`default_nettype none

// Sawtooth voice on a PHASE_BITS phase accumulator with FM and an exponential
// release tail. Requests on req_ carry a command in req_tuser: a tick produces
// exactly one result on rsp_; start, release and stop produce none and leave
// the request side ready. A tick of a silent voice goes straight to the emit
// state, which hands a zero result over once the output register is free. A
// tick of a sounding voice runs seven multiplies and two divides by 127
// on one shared shift-add multiplier and one restoring divider, both one bit
// per cycle: a multiply stops when no multiplier bits remain (operands of at
// most 17, 7, TAIL_BITS, 16, 32, 7 and TAIL_BITS-1 bits, the last only while a
// release runs), each divide yields a 25-bit quotient, and the result then
// waits in the emit state for a free output register; the next request is taken
// as soon as the result sits in the output register. The user must write
// volume and fm_depth through csr_ while the voice is idle; it is not enforced.
module saw_oscillator_fm_release #(
   parameter int PHASE_BITS = sofr_pkg::PHASE_BITS_DEF,
   parameter int TAIL_BITS  = sofr_pkg::TAIL_BITS_DEF
) (
   input  wire                              clock,
   input  wire                              reset,
   // request stream
   input  wire                              req_tvalid,
   output logic                             req_tready,
   // req_tdata: phase_step[30:0], note_level[46:31], fm_sample[62:47], zero pad
   input  wire  [sofr_pkg::REQ_DATA_W-1:0]  req_tdata,
   // req_tuser: command[1:0]
   input  wire  [sofr_pkg::REQ_USER_W-1:0]  req_tuser,
   // result stream
   output logic                             rsp_tvalid,
   input  wire                              rsp_tready,
   // rsp_tdata: sample_out[16:0], mod_out[32:17], zero pad
   output logic [sofr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // rsp_tuser: voice_active[0]
   output logic                             rsp_tuser,
   // register write port
   input  wire                              csr_we,
   input  wire  [sofr_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire  [sofr_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int STEP_W  = (PHASE_BITS < 31) ? PHASE_BITS : 31;
   localparam int PROD_S  = 40 + TAIL_BITS;
   localparam int PROD_E  = STEP_W + 32;
   localparam int MUL_W   = (PROD_S > PROD_E) ? PROD_S : PROD_E;
   localparam int unsigned TAIL_ONE   = 1 << (TAIL_BITS - 1);
   localparam int unsigned TAIL_DECAY = (99 * TAIL_ONE + 50) / 100;
   localparam int unsigned TAIL_END   = (TAIL_ONE + 199) / 200;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_AMP   = 11'b000_0000_0010,
      ST_VOL   = 11'b000_0000_0100,
      ST_TAIL  = 11'b000_0000_1000,
      ST_SDIV  = 11'b000_0001_0000,
      ST_FM    = 11'b000_0010_0000,
      ST_STEP  = 11'b000_0100_0000,
      ST_MOD   = 11'b000_1000_0000,
      ST_MDIV  = 11'b001_0000_0000,
      ST_DECAY = 11'b010_0000_0000,
      ST_EMIT  = 11'b100_0000_0000
   } state_type;

   // request fields
   sofr_pkg::command_type req_command;
   logic [30:0]           req_phase_step;
   logic [15:0]           req_note_level;
   logic signed [15:0]    req_fm_sample;

   assign req_command    = sofr_pkg::command_type'(req_tuser);
   assign req_phase_step = req_tdata[30:0];
   assign req_note_level = req_tdata[46:31];
   assign req_fm_sample  = req_tdata[62:47];

   // sequencer and voice state
   state_type                   state_ff, state_in;
   logic [PHASE_BITS-1:0]       phase_ff, phase_in;
   logic [STEP_W-1:0]           step_ff, step_in;
   logic [15:0]                 amp_ff, amp_in;
   logic [TAIL_BITS-1:0]        tail_ff, tail_in;
   logic                        sounding_ff, sounding_in;
   logic [6:0]                  volume_ff, volume_in;
   logic [15:0]                 depth_ff, depth_in;
   logic [15:0]                 fm_ff, fm_in;

   // serial multiplier
   logic [MUL_W-1:0]              acc_ff, acc_in;
   logic [MUL_W-1:0]              mcand_ff, mcand_in;
   logic [sofr_pkg::MPLIER_W-1:0] mplier_ff, mplier_in;

   // serial divider by 127
   logic [sofr_pkg::DIV_W-1:0]     dnum_ff, dnum_in;
   logic [6:0]                     rem_ff, rem_in;
   logic [sofr_pkg::DIV_CNT_W-1:0] dcnt_ff, dcnt_in;

   // result staging and output register
   logic [16:0]                     res_sample_ff, res_sample_in;
   logic [15:0]                     res_mod_ff, res_mod_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [sofr_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                            rsp_user_ff, rsp_user_in;

   // datapath helpers
   logic                       mul_run, mul_done, div_run, div_done, div_ge;
   logic [MUL_W-1:0]           mul_acc_step;
   logic [7:0]                 div_trial;
   logic [6:0]                 div_rem_next;
   logic [sofr_pkg::DIV_W-1:0] div_quot;
   logic [16:0]                div_sat;
   logic [15:0]                ph16_now, ph16_adv;
   logic [TAIL_BITS-1:0]       tail_eff, tail_next;
   logic [33:0]                fm_corr, fm_factor;
   logic [PHASE_BITS-1:0]      phase_adv;
   logic [MUL_W-1:0]           tail_round;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // shift-add step: one multiplier bit per cycle, done when no bits remain
   assign mul_run      = state_ff inside {ST_AMP, ST_VOL, ST_TAIL, ST_FM, ST_STEP, ST_MOD,
                                          ST_DECAY};
   assign mul_done     = (mplier_ff == '0);
   assign mul_acc_step = mplier_ff[0] ? acc_ff + mcand_ff : acc_ff;

   // restoring divide step: one quotient bit per cycle, MSB first
   assign div_run      = state_ff inside {ST_SDIV, ST_MDIV};
   assign div_done     = (dcnt_ff == sofr_pkg::DIV_CNT_W'(sofr_pkg::DIV_W - 1));
   assign div_trial    = {rem_ff, dnum_ff[sofr_pkg::DIV_W-1]};
   assign div_ge       = (div_trial >= sofr_pkg::VOL_DIVISOR);
   assign div_rem_next = div_ge ? 7'(div_trial - sofr_pkg::VOL_DIVISOR) : div_trial[6:0];
   assign div_quot     = {dnum_ff[sofr_pkg::DIV_W-2:0], div_ge};
   assign div_sat      = (div_quot > sofr_pkg::DIV_W'(sofr_pkg::SAMPLE_MAX)) ?
                         sofr_pkg::SAMPLE_MAX : div_quot[16:0];

   // gain is unity unless a release runs
   assign ph16_now = phase_ff[PHASE_BITS-1 -: 16];
   assign tail_eff = (tail_ff != '0) ? tail_ff : TAIL_BITS'(TAIL_ONE);

   // FM factor = 2^31 - fm*depth; acc holds depth times the raw fm bits,
   // so a negative fm adds back depth*2^16
   assign fm_corr   = fm_ff[15] ? {2'b00, depth_ff, 16'h0000} : '0;
   assign fm_factor = sofr_pkg::FM_UNITY + fm_corr - acc_ff[33:0];

   // phase advance by (step*factor) >> 31, wrapping
   assign phase_adv = phase_ff + PHASE_BITS'(acc_ff[MUL_W-1:31]);
   assign ph16_adv  = phase_adv[PHASE_BITS-1 -: 16];

   // tail decay, rounded half up
   assign tail_round = acc_ff + MUL_W'(TAIL_ONE / 2);
   assign tail_next  = tail_round[TAIL_BITS-1 +: TAIL_BITS];

   always_comb begin
      state_in      = state_ff;
      phase_in      = phase_ff;
      step_in       = step_ff;
      amp_in        = amp_ff;
      tail_in       = tail_ff;
      sounding_in   = sounding_ff;
      volume_in     = volume_ff;
      depth_in      = depth_ff;
      fm_in         = fm_ff;
      acc_in        = acc_ff;
      mcand_in      = mcand_ff;
      mplier_in     = mplier_ff;
      dnum_in       = dnum_ff;
      rem_in        = rem_ff;
      dcnt_in       = dcnt_ff;
      res_sample_in = res_sample_ff;
      res_mod_in    = res_mod_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      rsp_user_in   = rsp_user_ff;

      // register writes
      if (csr_we) begin
         case (csr_addr)
            sofr_pkg::CSR_VOLUME:   volume_in = csr_wdata[6:0];
            sofr_pkg::CSR_FM_DEPTH: depth_in  = csr_wdata;
            default: ;
         endcase
      end

      // running units
      if (mul_run && !mul_done) begin
         acc_in    = mul_acc_step;
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
      end
      if (div_run) begin
         dnum_in = div_quot;
         rem_in  = div_rem_next;
         dcnt_in = dcnt_ff + 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               case (req_command)
                  sofr_pkg::CMD_START: begin
                     phase_in    = '0;
                     step_in     = req_phase_step[STEP_W-1:0];
                     amp_in      = req_note_level;
                     tail_in     = '0;
                     sounding_in = (req_phase_step[STEP_W-1:0] != '0);
                  end
                  sofr_pkg::CMD_RELEASE: begin
                     if (tail_ff == '0) begin
                        tail_in = TAIL_BITS'(TAIL_ONE);
                     end
                  end
                  sofr_pkg::CMD_STOP: begin
                     step_in     = '0;
                     sounding_in = 1'b0;
                  end
                  default: begin
                     fm_in = req_fm_sample;
                     if (sounding_ff) begin
                        acc_in    = '0;
                        mcand_in  = MUL_W'(amp_ff);
                        mplier_in = sofr_pkg::MPLIER_W'({ph16_now, 1'b0});
                        state_in  = ST_AMP;
                     end else begin
                        res_sample_in = '0;
                        res_mod_in    = '0;
                        state_in      = ST_EMIT;
                     end
                  end
               endcase
            end
         end
         // level times twice the phase
         ST_AMP: begin
            if (mul_done) begin
               acc_in    = '0;
               mcand_in  = acc_ff;
               mplier_in = sofr_pkg::MPLIER_W'(volume_ff);
               state_in  = ST_VOL;
            end
         end
         // times volume
         ST_VOL: begin
            if (mul_done) begin
               acc_in    = '0;
               mcand_in  = acc_ff;
               mplier_in = sofr_pkg::MPLIER_W'(tail_eff);
               state_in  = ST_TAIL;
            end
         end
         // times tail gain, then scale down before the divide
         ST_TAIL: begin
            if (mul_done) begin
               dnum_in  = acc_ff[TAIL_BITS+15 +: sofr_pkg::DIV_W];
               rem_in   = '0;
               dcnt_in  = '0;
               state_in = ST_SDIV;
            end
         end
         ST_SDIV: begin
            if (div_done) begin
               res_sample_in = div_sat;
               acc_in        = '0;
               mcand_in      = MUL_W'(depth_ff);
               mplier_in     = sofr_pkg::MPLIER_W'(fm_ff);
               state_in      = ST_FM;
            end
         end
         // modulator times depth
         ST_FM: begin
            if (mul_done) begin
               acc_in    = '0;
               mcand_in  = MUL_W'(step_ff);
               mplier_in = sofr_pkg::MPLIER_W'(fm_factor);
               state_in  = ST_STEP;
            end
         end
         // step times FM factor, then advance the phase
         ST_STEP: begin
            if (mul_done) begin
               phase_in  = phase_adv;
               acc_in    = '0;
               mcand_in  = MUL_W'(ph16_adv);
               mplier_in = sofr_pkg::MPLIER_W'(volume_ff);
               state_in  = ST_MOD;
            end
         end
         // new phase times volume
         ST_MOD: begin
            if (mul_done) begin
               dnum_in  = acc_ff[sofr_pkg::DIV_W-1:0];
               rem_in   = '0;
               dcnt_in  = '0;
               state_in = ST_MDIV;
            end
         end
         ST_MDIV: begin
            if (div_done) begin
               res_mod_in = div_quot[15:0];
               if (tail_ff != '0) begin
                  acc_in    = '0;
                  mcand_in  = MUL_W'(tail_ff);
                  mplier_in = sofr_pkg::MPLIER_W'(TAIL_DECAY);
                  state_in  = ST_DECAY;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         // decay the tail; the voice ends at the end level
         ST_DECAY: begin
            if (mul_done) begin
               tail_in = tail_next;
               if (tail_next <= TAIL_BITS'(TAIL_END)) begin
                  sounding_in = 1'b0;
                  step_in     = '0;
               end
               state_in = ST_EMIT;
            end
         end
         // hand the result to the output register once it is free
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = sofr_pkg::RSP_DATA_W'({res_mod_ff, res_sample_ff});
               rsp_user_in  = sounding_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= '0;
         step_ff      <= '0;
         amp_ff       <= '0;
         tail_ff      <= '0;
         sounding_ff  <= 1'b0;
         volume_ff    <= sofr_pkg::VOLUME_RESET;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         step_ff      <= step_in;
         amp_ff       <= amp_in;
         tail_ff      <= tail_in;
         sounding_ff  <= sounding_in;
         volume_ff    <= volume_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fm_ff         <= fm_in;
      acc_ff        <= acc_in;
      mcand_ff      <= mcand_in;
      mplier_ff     <= mplier_in;
      dnum_ff       <= dnum_in;
      rem_ff        <= rem_in;
      dcnt_ff       <= dcnt_in;
      res_sample_ff <= res_sample_in;
      res_mod_ff    <= res_mod_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

endmodule

`default_nettype wire

[src/sofr_checker.sv]
`default_nettype none

`include "saw_oscillator_fm_release_macros.svh"

module sofr_checker (
   input wire                             clock,
   input wire                             reset,
   input wire                             req_tvalid,
   input wire                             req_tready,
   input wire [sofr_pkg::REQ_USER_W-1:0]  req_tuser,
   input wire                             rsp_tvalid,
   input wire                             rsp_tready,
   input wire [sofr_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire                             rsp_tuser
);

   logic tick_taken, cmd_taken;

   assign tick_taken = req_tvalid && req_tready && (req_tuser == sofr_pkg::CMD_TICK);
   assign cmd_taken  = req_tvalid && req_tready && (req_tuser != sofr_pkg::CMD_TICK);

   // a tick keeps the engine busy in the cycle after it is taken
   `SOFR_ASSERT_NEXT(a_tick_busy, tick_taken, !req_tready, "tick did not occupy the engine")

   // start, release and stop finish in the cycle they are taken
   `SOFR_ASSERT_NEXT(a_cmd_quick, cmd_taken, req_tready, "command held the request side")

   // a new result appears together with the engine going idle
   `SOFR_ASSERT_NOW(a_emit_idle, $rose(rsp_tvalid), req_tready, "result shown while busy")

   // a stalled result holds
   `SOFR_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
                     rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
                     "stalled result changed")

endmodule

bind saw_oscillator_fm_release sofr_checker u_sofr_checker (.*);

`default_nettype wire
